>>> src/vec3_pkg.sv
// Shared types and constants for the vector3 ALU.
`default_nettype none
package vec3_pkg;

  // Operation codes carried in the action field
  typedef enum logic [1:0] {
    ACT_DOT   = 2'd0,
    ACT_CROSS = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_NORM  = 2'd3
  } action_t;

  // Data that rides alongside the normalize datapath
  typedef struct packed {
    action_t          action;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] res;
    logic             sat;
  } side_t;

  // Front-end result: finished dot/cross/add values plus normalize operands
  typedef struct packed {
    side_t            side;
    logic [63:0]      len2;
    logic [2:0][62:0] sq;
  } front_t;

endpackage
`default_nettype wire

>>> src/vec3_if.sv
// Valid/ready channel interfaces for vector items and results.
`default_nettype none
interface vec3_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] p_x;
  logic signed [31:0] p_y;
  logic signed [31:0] p_z;
  logic signed [31:0] q_x;
  logic signed [31:0] q_y;
  logic signed [31:0] q_z;

  modport source (output valid, action, p_x, p_y, p_z, q_x, q_y, q_z, input ready);
  modport sink (input valid, action, p_x, p_y, p_z, q_x, q_y, q_z, output ready);
endinterface

interface vec3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic               saturated;
  logic               zero_length;

  modport source (output valid, res_x, res_y, res_z, saturated, zero_length, input ready);
  modport sink (input valid, res_x, res_y, res_z, saturated, zero_length, output ready);
endinterface
`default_nettype wire

>>> src/vec3_front.sv
// Front end: products, sums, rounding and clamping (three stages).
`default_nettype none
module vec3_front import vec3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [1:0]         action,
  input  logic signed [31:0] p_x,
  input  logic signed [31:0] p_y,
  input  logic signed [31:0] p_z,
  input  logic signed [31:0] q_x,
  input  logic signed [31:0] q_y,
  input  logic signed [31:0] q_z,
  output front_t             front_out
);

  localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] MAXW  = 66'sd2147483647;
  localparam logic signed [65:0] MINW  = -66'sd2147483648;
  localparam logic signed [32:0] MAXA  = 33'sd2147483647;
  localparam logic signed [32:0] MINA  = -33'sd2147483648;

  action_t            act_in;
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];

  // stage 1 registers
  action_t            act1;
  logic signed [63:0] prod1 [6];
  logic signed [32:0] add1 [3];
  logic [2:0]         neg1;
  logic               zero1;

  // stage 2 registers
  action_t            act2;
  logic signed [65:0] sum2 [3];
  logic signed [32:0] add2 [3];
  logic [2:0][62:0]   sq2;
  logic [63:0]        len2_2;
  logic [2:0]         neg2;
  logic               zero2;

  logic signed [65:0] sum_n [3];
  logic [63:0]        len_n;
  logic signed [65:0] rnd [3];
  logic [2:0][31:0]   cl;
  logic [2:0]         cs;
  logic [2:0][31:0]   al;
  logic [2:0]         as;
  logic [2:0][31:0]   res_n;
  logic               sat_n;

  assign act_in = action_t'(action);

  // Operand selection per operation
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (act_in)
      ACT_DOT: begin
        ma[0] = p_x; mb[0] = q_x;
        ma[1] = p_y; mb[1] = q_y;
        ma[2] = p_z; mb[2] = q_z;
      end
      ACT_CROSS: begin
        ma[0] = p_y; mb[0] = q_z;
        ma[1] = p_z; mb[1] = q_y;
        ma[2] = p_z; mb[2] = q_x;
        ma[3] = p_x; mb[3] = q_z;
        ma[4] = p_x; mb[4] = q_y;
        ma[5] = p_y; mb[5] = q_x;
      end
      ACT_NORM: begin
        ma[0] = p_x; mb[0] = p_x;
        ma[1] = p_y; mb[1] = p_y;
        ma[2] = p_z; mb[2] = p_z;
      end
      default: begin
      end
    endcase
  end

  // Stage 1: products and component sums
  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= act_in;
      for (int i = 0; i < 6; i++) begin
        prod1[i] <= ma[i] * mb[i];
      end
      add1[0] <= 33'(p_x) + 33'(q_x);
      add1[1] <= 33'(p_y) + 33'(q_y);
      add1[2] <= 33'(p_z) + 33'(q_z);
      neg1    <= {p_z[31], p_y[31], p_x[31]};
      zero1   <= (p_x == '0) && (p_y == '0) && (p_z == '0);
    end
  end

  // Exact sums of products
  always_comb begin
    if (act1 == ACT_CROSS) begin
      sum_n[0] = 66'(prod1[0]) - 66'(prod1[1]);
      sum_n[1] = 66'(prod1[2]) - 66'(prod1[3]);
      sum_n[2] = 66'(prod1[4]) - 66'(prod1[5]);
    end else begin
      sum_n[0] = 66'(prod1[0]) + 66'(prod1[1]) + 66'(prod1[2]);
      sum_n[1] = '0;
      sum_n[2] = '0;
    end
    len_n = 64'(prod1[0][62:0]) + 64'(prod1[1][62:0]) + 64'(prod1[2][62:0]);
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      act2   <= act1;
      sum2   <= sum_n;
      add2   <= add1;
      len2_2 <= len_n;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= prod1[i][62:0];
      end
      neg2   <= neg1;
      zero2  <= zero1;
    end
  end

  // Round to nearest (ties up), clamp, and pick the result set
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (sum2[i] + HALF) >>> FRAC_BITS;
      cs[i]  = 1'b0;
      cl[i]  = rnd[i][31:0];
      if (rnd[i] > MAXW) begin
        cl[i] = MAXW[31:0];
        cs[i] = 1'b1;
      end else if (rnd[i] < MINW) begin
        cl[i] = MINW[31:0];
        cs[i] = 1'b1;
      end
      as[i] = 1'b0;
      al[i] = add2[i][31:0];
      if (add2[i] > MAXA) begin
        al[i] = MAXA[31:0];
        as[i] = 1'b1;
      end else if (add2[i] < MINA) begin
        al[i] = MINA[31:0];
        as[i] = 1'b1;
      end
    end
    case (act2)
      ACT_DOT: begin
        res_n = {32'd0, 32'd0, cl[0]};
        sat_n = cs[0];
      end
      ACT_CROSS: begin
        res_n = cl;
        sat_n = |cs;
      end
      ACT_ADD: begin
        res_n = al;
        sat_n = |as;
      end
      default: begin
        res_n = '0;
        sat_n = 1'b0;
      end
    endcase
  end

  // Stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      front_out.side.action <= act2;
      front_out.side.zero   <= zero2;
      front_out.side.neg    <= neg2;
      front_out.side.res    <= res_n;
      front_out.side.sat    <= sat_n;
      front_out.len2        <= len2_2;
      front_out.sq          <= sq2;
    end
  end

endmodule
`default_nettype wire

>>> src/vec3_div.sv
// Pipelined restoring divider: squared component over squared length, three lanes.
`default_nettype none
module vec3_div import vec3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [63:0]                   len2,
  input  logic [2:0][62:0]              sq,
  output logic [2:0][2*FRAC_BITS+2:0]   quo
);

  localparam int QW = 2 * FRAC_BITS + 3;

  typedef struct packed {
    logic [63:0]         len2;
    logic [2:0][63:0]    rem;
    logic [2:0][QW-1:0]  quo;
  } dstage_t;

  dstage_t st [QW];

  // One quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [63:0]        len_in;
    logic [2:0][64:0]   num;
    logic [2:0][QW-1:0] quo_in;
    dstage_t            nxt;

    if (k == 0) begin : g_first
      assign len_in = len2;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign num[i] = {2'b00, sq[i]};
      end
      assign quo_in = '0;
    end else begin : g_next
      assign len_in = st[k-1].len2;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign num[i] = {st[k-1].rem[i], 1'b0};
      end
      assign quo_in = st[k-1].quo;
    end

    // compare and subtract
    always_comb begin
      logic [64:0] df;
      logic        ge;
      nxt.len2 = len_in;
      for (int i = 0; i < 3; i++) begin
        df = num[i] - {1'b0, len_in};
        ge = num[i] >= {1'b0, len_in};
        nxt.rem[i] = ge ? df[63:0] : num[i][63:0];
        nxt.quo[i] = {quo_in[i][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign quo = st[QW-1].quo;

endmodule
`default_nettype wire

>>> src/vec3_sqrt.sv
// Pipelined integer square root, two radicand bits per stage, three lanes.
`default_nettype none
module vec3_sqrt import vec3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2:0][2*FRAC_BITS+2:0]   rad_in,
  output logic [2:0][FRAC_BITS+1:0]     root
);

  localparam int QW = 2 * FRAC_BITS + 3;
  localparam int NS = FRAC_BITS + 2;
  localparam int SW = 2 * NS;
  localparam int RW = FRAC_BITS + 3;
  localparam int TW = RW + 2;

  typedef struct packed {
    logic [2:0][SW-1:0] rad;
    logic [2:0][RW-1:0] rem;
    logic [2:0][NS-1:0] root;
  } sstage_t;

  sstage_t st [NS];

  // One root bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [2:0][SW-1:0] rad_p;
    logic [2:0][RW-1:0] rem_p;
    logic [2:0][NS-1:0] root_p;
    sstage_t            nxt;

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rad_p[i] = {{(SW - QW){1'b0}}, rad_in[i]};
      end
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = st[j-1].rad;
      assign rem_p  = st[j-1].rem;
      assign root_p = st[j-1].root;
    end

    // trial subtract of 4*root+1
    always_comb begin
      logic [TW-1:0] t;
      logic [TW-1:0] trial;
      logic [TW-1:0] df;
      logic          ge;
      nxt.rad = rad_p;
      for (int i = 0; i < 3; i++) begin
        t     = {rem_p[i], rad_p[i][SW-1-2*j -: 2]};
        trial = {1'b0, root_p[i], 2'b01};
        df    = t - trial;
        ge    = t >= trial;
        nxt.rem[i]  = ge ? df[RW-1:0] : t[RW-1:0];
        nxt.root[i] = {root_p[i][NS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= nxt;
      end
    end
  end

  assign root = st[NS-1].root;

endmodule
`default_nettype wire

>>> src/vector3_alu.sv
// Components are Q16.16 at FRAC_BITS=16. Throughput: one item per cycle while the
// output is not held; the normalize divider (2*FRAC_BITS+3 stages) and
// square root (FRAC_BITS+2 stages) set the depth, and every operation takes that path.
// A held result stalls the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and the output register's valid; payload is not reset.
`default_nettype none
module vector3_alu import vec3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  vec3_in_if.sink           vec,
  vec3_out_if.source        result
);

  localparam int QW = 2 * FRAC_BITS + 3;
  localparam int NS = FRAC_BITS + 2;
  localparam int DL = QW + NS;
  localparam int VL = 3 + DL;

  logic                   en;
  logic [VL-1:0]          vld;
  logic                   out_valid;
  logic signed [31:0]     out_x;
  logic signed [31:0]     out_y;
  logic signed [31:0]     out_z;
  logic                   out_sat;
  logic                   out_zero;

  front_t                 front;
  logic [2:0][QW-1:0]     quo;
  logic [2:0][NS-1:0]     root;
  side_t                  sd [DL];

  logic [2:0][NS:0]       half_up;
  logic [2:0][31:0]       comp;
  logic [2:0][31:0]       res_n;
  logic                   sat_n;
  logic                   zero_n;

  // Global advance: output register empty or being taken; no input transfer in reset
  assign en        = !out_valid || result.ready;
  assign vec.ready = en && !rst;

  vec3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .en        (en),
    .action    (vec.action),
    .p_x       (vec.p_x),
    .p_y       (vec.p_y),
    .p_z       (vec.p_z),
    .q_x       (vec.q_x),
    .q_y       (vec.q_y),
    .q_z       (vec.q_z),
    .front_out (front)
  );

  vec3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .en   (en),
    .len2 (front.len2),
    .sq   (front.sq),
    .quo  (quo)
  );

  vec3_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_in (quo),
    .root   (root)
  );

  // Side data delay matching divider plus square root depth
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= front.side;
      for (int k = 1; k < DL; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[VL-2:0], vec.valid};
      out_valid <= vld[VL-1];
    end
  end

  // Round root to the unit component (ties away), apply sign, select result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      half_up[i] = {1'b0, root[i]} + 1'b1;
      comp[i]    = 32'(half_up[i][NS:1]);
      if (sd[DL-1].neg[i]) begin
        comp[i] = -comp[i];
      end
    end
    if (sd[DL-1].action == ACT_NORM) begin
      res_n  = sd[DL-1].zero ? '0 : comp;
      sat_n  = 1'b0;
      zero_n = sd[DL-1].zero;
    end else begin
      res_n  = sd[DL-1].res;
      sat_n  = sd[DL-1].sat;
      zero_n = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= res_n[0];
      out_y    <= res_n[1];
      out_z    <= res_n[2];
      out_sat  <= sat_n;
      out_zero <= zero_n;
    end
  end

  assign result.valid       = out_valid;
  assign result.res_x       = out_x;
  assign result.res_y       = out_y;
  assign result.res_z       = out_z;
  assign result.saturated   = out_sat;
  assign result.zero_length = out_zero;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the vector3 ALU: directed table, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import vec3_pkg::*;

  localparam int FRAC = 16;
  localparam int PERIOD = 12;
  localparam int LATENCY = 3 * FRAC + 9;
  localparam int RANDOM_ITEMS = 850;
  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct {
    action_t            act;
    logic signed [31:0] px, py, pz, qx, qy, qz;
  } vec_item_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               sat, zero;
  } vec_result_t;

  typedef struct {
    vec_item_t   item;
    logic        typed;
    vec_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  vec3_in_if  in_ch ();
  vec3_out_if out_ch ();

  vec_result_t pending_results[$];
  int errors = 0;
  int matched = 0;
  int act_count[4] = '{0, 0, 0, 0};
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles = 0;

  vector3_alu #(.FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst(rst),
    .vec(in_ch),
    .result(out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // Round half toward plus infinity, drop fraction, clamp to 32 bits
  function automatic logic signed [31:0] round_clamp(input logic signed [67:0] acc,
                                                     inout logic sat);
    logic signed [67:0] r;
    r = (acc + (68'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (r > 68'(MAXV)) begin
      sat = 1'b1;
      return MAXV;
    end
    if (r < 68'(MINV)) begin
      sat = 1'b1;
      return MINV;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] sum_clamp(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   inout logic sat);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'(MAXV)) begin
      sat = 1'b1;
      return MAXV;
    end
    if (s < 33'(MINV)) begin
      sat = 1'b1;
      return MINV;
    end
    return s[31:0];
  endfunction

  // Largest m with (m - 1/2) <= |v| * 2^FRAC / sqrt(len2): round half away from zero
  function automatic logic signed [31:0] unit_comp(input logic signed [31:0] v,
                                                   input logic [63:0] len2);
    logic signed [63:0] wide;
    logic [63:0]  mag, lo, hi, mid, t;
    logic [127:0] rhs, lhs;
    wide = 64'(v);
    mag = (wide < 0) ? -wide : wide;
    rhs = 128'(mag * mag) << (2 * FRAC + 2);
    lo = 0;
    hi = 64'd1 << FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      lhs = 128'(t * t) * 128'(len2);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (wide < 0) ? -32'(lo) : 32'(lo);
  endfunction

  function automatic vec_result_t vector_op(input vec_item_t it);
    vec_result_t r;
    logic signed [67:0] a, b, c;
    logic signed [63:0] wx, wy, wz;
    logic [63:0] len2;
    r = '{x: 0, y: 0, z: 0, sat: 1'b0, zero: 1'b0};
    case (it.act)
      ACT_DOT: begin
        a = 68'(it.px) * 68'(it.qx);
        b = 68'(it.py) * 68'(it.qy);
        c = 68'(it.pz) * 68'(it.qz);
        r.x = round_clamp(a + b + c, r.sat);
      end
      ACT_CROSS: begin
        r.x = round_clamp(68'(it.py) * 68'(it.qz) - 68'(it.pz) * 68'(it.qy), r.sat);
        r.y = round_clamp(68'(it.pz) * 68'(it.qx) - 68'(it.px) * 68'(it.qz), r.sat);
        r.z = round_clamp(68'(it.px) * 68'(it.qy) - 68'(it.py) * 68'(it.qx), r.sat);
      end
      ACT_ADD: begin
        r.x = sum_clamp(it.px, it.qx, r.sat);
        r.y = sum_clamp(it.py, it.qy, r.sat);
        r.z = sum_clamp(it.pz, it.qz, r.sat);
      end
      default: begin
        wx = 64'(it.px);
        wy = 64'(it.py);
        wz = 64'(it.pz);
        len2 = wx * wx + wy * wy + wz * wz;
        if (len2 == 0) begin
          r.zero = 1'b1;
        end else begin
          r.x = unit_comp(it.px, len2);
          r.y = unit_comp(it.py, len2);
          r.z = unit_comp(it.pz, len2);
        end
      end
    endcase
    return r;
  endfunction

  // One random component: full range, small, extreme, or moderate Q16.16
  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(64)) - 32'sd32;
      2: begin
        case ($urandom_range(4))
          0: return MAXV;
          1: return MINV;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return ONE;
        endcase
      end
      default: return 32'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    vec_item_t it;
    it.act = action_t'($urandom_range(3));
    it.px = rand_comp();
    it.py = rand_comp();
    it.pz = rand_comp();
    it.qx = rand_comp();
    it.qy = rand_comp();
    it.qz = rand_comp();
    if (it.act == ACT_NORM && $urandom_range(19) == 0) begin
      it.px = 0;
      it.py = 0;
      it.pz = 0;
    end
    return it;
  endfunction

  // Offer one item at falling edges; wait for the transfer at a rising edge
  task automatic send_item(input vec_item_t it, input logic typed, input vec_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= it.act;
    in_ch.p_x <= it.px;
    in_ch.p_y <= it.py;
    in_ch.p_z <= it.pz;
    in_ch.q_x <= it.qx;
    in_ch.q_y <= it.qy;
    in_ch.q_z <= it.qz;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(typed ? want : vector_op(it));
    act_count[it.act]++;
  endtask

  // Receiver: random stalls, plus a long hold when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    vec_result_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("res_x", w.x, out_ch.res_x);
        check_field("res_y", w.y, out_ch.res_y);
        check_field("res_z", w.z, out_ch.res_z);
        check_field("saturated", 32'(w.sat), 32'(out_ch.saturated));
        check_field("zero_length", 32'(w.zero), 32'(out_ch.zero_length));
        matched++;
      end
    end
  end

  // Main sequence
  initial begin
    stim_row_t   rows[$];
    vec_result_t none;
    int          waited;
    none = '{x: 0, y: 0, z: 0, sat: 1'b0, zero: 1'b0};
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_DOT;
    in_ch.p_x = 0;
    in_ch.p_y = 0;
    in_ch.p_z = 0;
    in_ch.q_x = 0;
    in_ch.q_y = 0;
    in_ch.q_z = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: typed results where obvious, predictor otherwise
    rows = '{
      '{'{ACT_DOT, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
      '{'{ACT_DOT, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1, '{32'sh30000, 0, 0, 1'b0, 1'b0}},
      '{'{ACT_DOT, 1, 0, 0, 32'sh8000, 0, 0}, 1'b1, '{1, 0, 0, 1'b0, 1'b0}},
      '{'{ACT_DOT, -1, 0, 0, 32'sh8000, 0, 0}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
      '{'{ACT_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b1, '{MAXV, 0, 0, 1'b1, 1'b0}},
      '{'{ACT_DOT, MINV, MINV, MINV, MINV, MINV, MINV}, 1'b1, '{MAXV, 0, 0, 1'b1, 1'b0}},
      '{'{ACT_DOT, MINV, MINV, MINV, MAXV, MAXV, MAXV}, 1'b1, '{MINV, 0, 0, 1'b1, 1'b0}},
      '{'{ACT_CROSS, ONE, 0, 0, 0, ONE, 0}, 1'b1, '{0, 0, ONE, 1'b0, 1'b0}},
      '{'{ACT_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV}, 1'b0, none},
      '{'{ACT_CROSS, 3, -7, 11, 32'sh8000, -32'sh8000, 5}, 1'b0, none},
      '{'{ACT_ADD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b1, '{MAXV, MAXV, MAXV, 1'b1, 1'b0}},
      '{'{ACT_ADD, MINV, MINV, MINV, MINV, MINV, MINV}, 1'b1, '{MINV, MINV, MINV, 1'b1, 1'b0}},
      '{'{ACT_ADD, MAXV, MINV, 0, MINV, MAXV, -1}, 1'b1, '{-1, -1, -1, 1'b0, 1'b0}},
      '{'{ACT_ADD, MAXV, 0, 0, 1, 0, 0}, 1'b1, '{MAXV, 0, 0, 1'b1, 1'b0}},
      '{'{ACT_NORM, 0, 0, 0, MAXV, MINV, -1}, 1'b1, '{0, 0, 0, 1'b0, 1'b1}},
      '{'{ACT_NORM, ONE, 0, 0, 0, 0, 0}, 1'b1, '{ONE, 0, 0, 1'b0, 1'b0}},
      '{'{ACT_NORM, 0, -5, 0, 0, 0, 0}, 1'b1, '{0, -ONE, 0, 1'b0, 1'b0}},
      '{'{ACT_NORM, MINV, MINV, MINV, 0, 0, 0}, 1'b0, none},
      '{'{ACT_NORM, MAXV, MAXV, MAXV, 0, 0, 0}, 1'b0, none},
      '{'{ACT_NORM, MAXV, 1, MINV, 0, 0, 0}, 1'b0, none},
      '{'{ACT_NORM, 1, 1, 0, 0, 0, 0}, 1'b0, none},
      '{'{ACT_NORM, 3, -4, 0, 0, 0, 0}, 1'b0, none}
    };
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    // Random traffic in three stall profiles
    src_idle_pct = 16;
    snk_idle_pct = 68;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_item(rand_item(), 1'b0, none);
    src_idle_pct = 68;
    snk_idle_pct = 16;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_item(rand_item(), 1'b0, none);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_cycles = 4 * LATENCY + 100;   // back up the pipe and stall the input
    for (int n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); n++)
      send_item(rand_item(), 1'b0, none);
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain, then watch for strays
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("covered %0d dot, %0d cross, %0d add, %0d normalize transfers;",
             act_count[ACT_DOT], act_count[ACT_CROSS], act_count[ACT_ADD],
             act_count[ACT_NORM]);
    $display("%0d results matched under three stall profiles and a long hold", matched);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/vec3_pkg.sv
src/vec3_if.sv
src/vec3_front.sv
src/vec3_div.sv
src/vec3_sqrt.sv
src/vector3_alu.sv
tb/testbench.sv
